// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the session retry controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHRF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHRF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/shrf_pkg.sv =====
// ----------------------------------------------------------------------------
// shrf_pkg
// Types and constants of the session handshake retry controller.
// ----------------------------------------------------------------------------
package shrf_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_POLL  = 2'd1,
        CMD_FRAME = 2'd2,
        CMD_SEAL  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        FK_EMPTY     = 2'd0,
        FK_HS_RESP   = 2'd1,
        FK_TRANSPORT = 2'd2,
        FK_OTHER     = 2'd3
    } frame_kind_t;

    typedef enum logic [1:0] {
        CR_OK        = 2'd0,
        CR_REPLAY    = 2'd1,
        CR_EXHAUSTED = 2'd2,
        CR_FAIL      = 2'd3
    } crypto_t;

    typedef enum logic [3:0] {
        ST_IDLE        = 4'd0,
        ST_HS_SENT     = 4'd1,
        ST_ESTAB       = 4'd2,
        ST_OPENED      = 4'd3,
        ST_SEALED      = 4'd4,
        ST_INPUT_ERR   = 4'd5,
        ST_STATE_ERR   = 4'd6,
        ST_REPLAY      = 4'd7,
        ST_EXHAUSTED   = 4'd8,
        ST_CRYPTO_FAIL = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        MODE_DOWN = 2'd0,
        MODE_HS   = 2'd1,
        MODE_EST  = 2'd2
    } mode_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_CAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_SLOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT = 3'd4;

    localparam logic [31:0] RETRY_MIN_RST  = 32'd1000000;
    localparam logic [31:0] RETRY_CAP_RST  = 32'd16000000;
    localparam logic [31:0] RETRY_SLOW_RST = 32'd30000000;
    localparam logic [31:0] SILENCE_RST    = 32'd5000000;
    localparam logic [7:0]  FAIL_LIMIT_RST = 8'd3;
    localparam logic [7:0]  FAIL_SAT       = 8'd255;

    // (interval / 4) * byte, and the jitter after the divide by 255
    localparam int PROD_W = 38;
    localparam int JIT_W  = 30;

    typedef struct packed {
        logic [31:0] retry_min;
        logic [31:0] retry_cap;
        logic [31:0] retry_slow;
        logic [31:0] silence_limit;
        logic [7:0]  fail_limit;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] now;
        frame_kind_t kind;
        crypto_t     cr;
        logic        fits;
        logic [7:0]  rnd;
    } item_t;

    typedef struct packed {
        status_t     status;
        mode_t       link_state;
        logic [31:0] hs_count;
    } res_t;

    typedef struct packed {
        logic             busy;
        logic             add_vld;
        logic [JIT_W-1:0] value;
    } jit_t;

    function automatic status_t crypto_status(crypto_t cr);
        status_t st;
        unique case (cr)
            CR_REPLAY:    st = ST_REPLAY;
            CR_EXHAUSTED: st = ST_EXHAUSTED;
            default:      st = ST_CRYPTO_FAIL;
        endcase
        return st;
    endfunction

endpackage

// ===== rtl/session_handshake_retry_fsm.sv =====
// ----------------------------------------------------------------------------
// session_handshake_retry_fsm
// Link-state controller of an encrypted session with jittered backoff.
// ----------------------------------------------------------------------------
// One event word per cycle, stalled while the jitter unit is busy or while a
// held result waits on m_ready: a word is registered on entry, handled in one
// pass against the link state and leaves through a registered result. A poll
// that sends a handshake initiation starts the jitter unit ((interval / 4) *
// random_byte / 255, a multiply stage and a divide stage); the word behind it
// waits while that unit adds the jitter into the retry deadline.
`include "assert_macros.svh"

module session_handshake_retry_fsm import shrf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [63:0]          s_now_time_us,
    input  logic [1:0]           s_frame_kind,
    input  logic [1:0]           s_crypto_result,
    input  logic                 s_buffer_fits,
    input  logic [7:0]           s_random_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_status,
    output logic [1:0]           m_link_state,
    output logic [31:0]          m_handshake_count
);

    cfg_t        cfg;
    jit_t        jit;
    logic        jit_start;
    logic [31:0] jit_interval;
    res_t        res;

    logic        in_vld_reg;
    item_t       in_item_reg;
    logic        out_vld_reg;
    res_t        out_res_reg;
    logic        fire;

    assign cfg_ready = 1'b1;
    assign fire      = in_vld_reg && !jit.busy && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.cmd  <= cmd_t'(s_cmd);
            in_item_reg.now  <= s_now_time_us;
            in_item_reg.kind <= frame_kind_t'(s_frame_kind);
            in_item_reg.cr   <= crypto_t'(s_crypto_result);
            in_item_reg.fits <= s_buffer_fits;
            in_item_reg.rnd  <= s_random_byte;
        end
        if (fire) begin
            out_res_reg <= res;
        end
    end

    shrf_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    shrf_jitter u_jitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (jit_start),
        .interval (jit_interval),
        .rnd      (in_item_reg.rnd),
        .jit      (jit)
    );

    shrf_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .item         (in_item_reg),
        .cfg          (cfg),
        .jit          (jit),
        .jit_start    (jit_start),
        .jit_interval (jit_interval),
        .res          (res)
    );

    assign m_valid           = out_vld_reg;
    assign m_status          = out_res_reg.status;
    assign m_link_state      = out_res_reg.link_state;
    assign m_handshake_count = out_res_reg.hs_count;

    `SHRF_ASSERT_NEXT(a_in_held, aclk, aresetn, in_vld_reg && !fire, in_vld_reg, "pending word dropped")

endmodule

// ===== rtl/shrf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// shrf_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module shrf_cfg_regs import shrf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [31:0]          wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_RETRY_MIN:  cfg_next.retry_min     = wr_data;
                CFG_RETRY_CAP:  cfg_next.retry_cap     = wr_data;
                CFG_RETRY_SLOW: cfg_next.retry_slow    = wr_data;
                CFG_SILENCE:    cfg_next.silence_limit = wr_data;
                CFG_FAIL_LIMIT: cfg_next.fail_limit    = wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retry_min     <= RETRY_MIN_RST;
            cfg_reg.retry_cap     <= RETRY_CAP_RST;
            cfg_reg.retry_slow    <= RETRY_SLOW_RST;
            cfg_reg.silence_limit <= SILENCE_RST;
            cfg_reg.fail_limit    <= FAIL_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/shrf_jitter.sv =====
// ----------------------------------------------------------------------------
// shrf_jitter
// Two-stage jitter unit: (interval / 4) * byte, then divide by 255.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shrf_jitter import shrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] interval,
    input  logic [7:0]  rnd,
    output jit_t        jit
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              prod_vld_reg;
    logic [JIT_W-1:0]  jit_reg;
    logic [JIT_W-1:0]  jit_next;
    logic              jit_vld_reg;

    logic [JIT_W:0]    q0_sum;
    logic [JIT_W-1:0]  q0;
    logic [PROD_W-1:0] q0_x255;
    logic [PROD_W-1:0] rem_full;
    logic [10:0]       rem;
    logic [11:0]       corr_sum;

    assign prod_next = PROD_W'(interval[31:2]) * PROD_W'(rnd);

    // x/255 from the series x/256 + x/65536 + ..., underestimates by at most 4
    always_comb begin
        q0_sum   = (JIT_W+1)'(prod_reg[PROD_W-1:8]) + (JIT_W+1)'(prod_reg[PROD_W-1:16])
                 + (JIT_W+1)'(prod_reg[PROD_W-1:24]) + (JIT_W+1)'(prod_reg[PROD_W-1:32]);
        q0       = q0_sum[JIT_W-1:0];
        q0_x255  = {q0, 8'b0} - PROD_W'(q0);
        rem_full = prod_reg - q0_x255;
        rem      = rem_full[10:0];
        corr_sum = 12'(rem) + 12'(rem[10:8]) + 12'd1;
        jit_next = q0 + JIT_W'(corr_sum[11:8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            jit_vld_reg  <= 1'b0;
        end else begin
            prod_vld_reg <= start;
            jit_vld_reg  <= prod_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= prod_next;
        end
        if (prod_vld_reg) begin
            jit_reg <= jit_next;
        end
    end

    assign jit.busy    = prod_vld_reg | jit_vld_reg;
    assign jit.add_vld = jit_vld_reg;
    assign jit.value   = jit_reg;

    `SHRF_ASSERT_NOW(a_jit_one_stage, aclk, aresetn, 1'b1, $onehot0({prod_vld_reg, jit_vld_reg}), "jitter unit holds two words")
    `SHRF_ASSERT_NOW(a_jit_start_idle, aclk, aresetn, start, !jit.busy, "jitter started while busy")

endmodule

// ===== rtl/shrf_core.sv =====
// ----------------------------------------------------------------------------
// shrf_core
// Link state, retry backoff, silence and decrypt-failure handling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shrf_core import shrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  item_t       item,
    input  cfg_t        cfg,
    input  jit_t        jit,
    output logic        jit_start,
    output logic [31:0] jit_interval,
    output res_t        res
);

    mode_t       mode_reg,     mode_next;
    logic [63:0] deadline_reg, deadline_next;
    logic [63:0] last_good_reg, last_good_next;
    logic [31:0] interval_reg, interval_next;
    logic [7:0]  fail_reg,     fail_next;
    logic [31:0] cnt_reg,      cnt_next;

    logic [63:0] elapsed;
    logic        poll_est;
    logic        poll_hs;
    logic        init_req;
    logic        init_ok;
    logic [31:0] ibase;
    logic [32:0] interval_x2;
    logic [31:0] widened;
    logic [7:0]  fail_inc;
    logic        transport_err;
    logic        rekey;
    logic        hs_done;
    logic        opened;
    status_t     status;

    always_comb begin
        elapsed  = item.now - last_good_reg;
        poll_est = (item.cmd == CMD_POLL) && (mode_reg == MODE_EST)
                && (elapsed >= {32'd0, cfg.silence_limit});
        poll_hs  = (item.cmd == CMD_POLL) && (mode_reg == MODE_HS)
                && (item.now >= deadline_reg);
        init_req = poll_est || poll_hs;
        init_ok  = init_req && item.fits && (item.cr == CR_OK);
        ibase    = poll_est ? cfg.retry_min : interval_reg;

        interval_x2 = {interval_reg, 1'b0};
        if (interval_reg >= cfg.retry_cap) begin
            widened = cfg.retry_slow;
        end else if (interval_x2 > {1'b0, cfg.retry_cap}) begin
            widened = cfg.retry_cap;
        end else begin
            widened = interval_x2[31:0];
        end

        fail_inc      = (fail_reg == FAIL_SAT) ? FAIL_SAT : fail_reg + 8'd1;
        transport_err = (item.cmd == CMD_FRAME) && (item.kind == FK_TRANSPORT)
                     && (mode_reg == MODE_EST) && item.fits && (item.cr != CR_OK);
        opened        = (item.cmd == CMD_FRAME) && (item.kind == FK_TRANSPORT)
                     && (mode_reg == MODE_EST) && item.fits && (item.cr == CR_OK);
        hs_done       = (item.cmd == CMD_FRAME) && (item.kind == FK_HS_RESP)
                     && (mode_reg == MODE_HS) && (item.cr == CR_OK);
        rekey         = (transport_err && (item.cr != CR_REPLAY)
                         && (fail_inc >= cfg.fail_limit))
                     || ((item.cmd == CMD_SEAL) && (mode_reg == MODE_EST) && item.fits
                         && (item.cr == CR_EXHAUSTED));
    end

    // status of the word
    always_comb begin
        status = ST_IDLE;
        unique case (item.cmd)
            CMD_START: status = ST_IDLE;
            CMD_POLL: begin
                priority if (!init_req)          status = ST_IDLE;
                else if (!item.fits)             status = ST_INPUT_ERR;
                else if (item.cr != CR_OK)       status = crypto_status(item.cr);
                else                             status = ST_HS_SENT;
            end
            CMD_FRAME: begin
                unique case (item.kind)
                    FK_HS_RESP: begin
                        priority if (mode_reg != MODE_HS) status = ST_STATE_ERR;
                        else if (item.cr != CR_OK)        status = crypto_status(item.cr);
                        else                              status = ST_ESTAB;
                    end
                    FK_TRANSPORT: begin
                        priority if (mode_reg != MODE_EST) status = ST_STATE_ERR;
                        else if (!item.fits)               status = ST_INPUT_ERR;
                        else if (item.cr != CR_OK)         status = crypto_status(item.cr);
                        else                               status = ST_OPENED;
                    end
                    default: status = ST_INPUT_ERR;
                endcase
            end
            CMD_SEAL: begin
                priority if (mode_reg != MODE_EST) status = ST_STATE_ERR;
                else if (!item.fits)               status = ST_INPUT_ERR;
                else if (item.cr == CR_OK)         status = ST_SEALED;
                else                               status = crypto_status(item.cr);
            end
            default: status = ST_IDLE;
        endcase
    end

    // link mode
    always_comb begin
        mode_next = mode_reg;
        if (fire) begin
            priority if (item.cmd == CMD_START) mode_next = MODE_HS;
            else if (init_ok || rekey)          mode_next = MODE_HS;
            else if (hs_done)                   mode_next = MODE_EST;
            else                                mode_next = mode_reg;
        end
    end

    // timers and counters
    always_comb begin
        deadline_next  = deadline_reg;
        last_good_next = last_good_reg;
        interval_next  = interval_reg;
        fail_next      = fail_reg;
        cnt_next       = cnt_reg;
        if (fire) begin
            unique case (item.cmd)
                CMD_START: begin
                    last_good_next = item.now;
                    interval_next  = cfg.retry_min;
                    deadline_next  = item.now;
                    fail_next      = 8'd0;
                    cnt_next       = 32'd0;
                end
                CMD_POLL: begin
                    if (poll_est) begin
                        interval_next = cfg.retry_min;
                    end
                    if (poll_hs) begin
                        interval_next = widened;
                    end
                    if (init_ok) begin
                        fail_next     = 8'd0;
                        deadline_next = item.now + {32'd0, ibase};
                        cnt_next      = cnt_reg + 32'd1;
                    end
                end
                CMD_FRAME: begin
                    if (hs_done || opened) begin
                        fail_next      = 8'd0;
                        last_good_next = item.now;
                    end
                    if (transport_err && (item.cr != CR_REPLAY)) begin
                        fail_next = fail_inc;
                    end
                    if (rekey) begin
                        interval_next = cfg.retry_min;
                        deadline_next = 64'd0;
                    end
                end
                CMD_SEAL: begin
                    if (rekey) begin
                        interval_next = cfg.retry_min;
                        deadline_next = 64'd0;
                    end
                end
                default: ;
            endcase
        end else if (jit.add_vld) begin
            deadline_next = deadline_reg + {{(64-JIT_W){1'b0}}, jit.value};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_HS;
            deadline_reg  <= 64'd0;
            last_good_reg <= 64'd0;
            interval_reg  <= RETRY_MIN_RST;
            fail_reg      <= 8'd0;
            cnt_reg       <= 32'd0;
        end else begin
            mode_reg      <= mode_next;
            deadline_reg  <= deadline_next;
            last_good_reg <= last_good_next;
            interval_reg  <= interval_next;
            fail_reg      <= fail_next;
            cnt_reg       <= cnt_next;
        end
    end

    assign jit_start      = fire && init_ok;
    assign jit_interval   = ibase;
    assign res.status     = status;
    assign res.link_state = mode_next;
    assign res.hs_count   = cnt_next;

    `SHRF_ASSERT_NOW(a_mode_never_down, aclk, aresetn, 1'b1, (mode_reg == MODE_HS) || (mode_reg == MODE_EST), "link mode left handshaking/established")
    `SHRF_ASSERT_NEXT(a_cnt_step, aclk, aresetn, fire && init_ok, cnt_reg == $past(cnt_reg) + 32'd1, "initiation not counted")

endmodule
